>>> hw/rtl/pl0_token_scanner_core_macros.svh
// Assertion shorthands shared by the scanner RTL.
`ifndef PL0_TOKEN_SCANNER_CORE_MACROS_SVH
`define PL0_TOKEN_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PL0TS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PL0TS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pl0ts_pkg.sv
`timescale 1ns / 1ps
package pl0ts_pkg;

  localparam int NAME_CHARS = 8;
  localparam int KW_COUNT   = 17;

  // Scan modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_NAME    = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_COLON   = 3'd3;
  localparam logic [2:0] MODE_LESS    = 3'd4;
  localparam logic [2:0] MODE_GREATER = 3'd5;
  localparam logic [2:0] MODE_COMMENT = 3'd6;

  // Token kinds
  localparam logic [5:0] KIND_END      = 6'd0;
  localparam logic [5:0] KIND_NAME     = 6'd1;
  localparam logic [5:0] KIND_NUMBER   = 6'd2;
  localparam logic [5:0] KIND_BEGIN    = 6'd3;
  localparam logic [5:0] KIND_KW_END   = 6'd4;
  localparam logic [5:0] KIND_IF       = 6'd5;
  localparam logic [5:0] KIND_THEN     = 6'd6;
  localparam logic [5:0] KIND_WHILE    = 6'd7;
  localparam logic [5:0] KIND_DO       = 6'd8;
  localparam logic [5:0] KIND_RETURN   = 6'd9;
  localparam logic [5:0] KIND_FUNCTION = 6'd10;
  localparam logic [5:0] KIND_VAR      = 6'd11;
  localparam logic [5:0] KIND_CONST    = 6'd12;
  localparam logic [5:0] KIND_ODD      = 6'd13;
  localparam logic [5:0] KIND_WRITE    = 6'd14;
  localparam logic [5:0] KIND_WRITELN  = 6'd15;
  localparam logic [5:0] KIND_CLASS    = 6'd16;
  localparam logic [5:0] KIND_ENDTYPE  = 6'd17;
  localparam logic [5:0] KIND_OBJECT   = 6'd18;
  localparam logic [5:0] KIND_PLUS     = 6'd19;
  localparam logic [5:0] KIND_MINUS    = 6'd20;
  localparam logic [5:0] KIND_TIMES    = 6'd21;
  localparam logic [5:0] KIND_SLASH    = 6'd22;
  localparam logic [5:0] KIND_LPAREN   = 6'd23;
  localparam logic [5:0] KIND_RPAREN   = 6'd24;
  localparam logic [5:0] KIND_EQL      = 6'd25;
  localparam logic [5:0] KIND_LSS      = 6'd26;
  localparam logic [5:0] KIND_GTR      = 6'd27;
  localparam logic [5:0] KIND_NOTEQ    = 6'd28;
  localparam logic [5:0] KIND_LSSEQ    = 6'd29;
  localparam logic [5:0] KIND_GTREQ    = 6'd30;
  localparam logic [5:0] KIND_COMMA    = 6'd31;
  localparam logic [5:0] KIND_PERIOD   = 6'd32;
  localparam logic [5:0] KIND_SEMI     = 6'd33;
  localparam logic [5:0] KIND_ASSIGN   = 6'd34;
  localparam logic [5:0] KIND_LBRACK   = 6'd35;
  localparam logic [5:0] KIND_RBRACK   = 6'd36;
  localparam logic [5:0] KIND_CARET    = 6'd37;
  localparam logic [5:0] KIND_AMP      = 6'd38;
  localparam logic [5:0] KIND_COLON    = 6'd39;
  localparam logic [5:0] KIND_OTHER    = 6'd40;

  // Source bytes with special meaning
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREATR = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Keyword table: text packed first byte low, length, kind
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_006E_6967_6562, // begin
    64'h0000_0000_0064_6E65, // end
    64'h0000_0000_0000_6669, // if
    64'h0000_0000_6E65_6874, // then
    64'h0000_0065_6C69_6877, // while
    64'h0000_0000_0000_6F64, // do
    64'h0000_6E72_7574_6572, // return
    64'h6E6F_6974_636E_7566, // function
    64'h0000_0000_0072_6176, // var
    64'h0000_0074_736E_6F63, // const
    64'h0000_0000_0064_646F, // odd
    64'h0000_0065_7469_7277, // write
    64'h006E_6C65_7469_7277, // writeln
    64'h0000_7463_7572_7473, // struct
    64'h0000_0073_7361_6C63, // class
    64'h0065_7079_7464_6E65, // endtype
    64'h0000_7463_656A_626F  // object
  };
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd5, 8'd3, 8'd2, 8'd4, 8'd5, 8'd2, 8'd6, 8'd8, 8'd3,
    8'd5, 8'd3, 8'd5, 8'd7, 8'd6, 8'd5, 8'd7, 8'd6
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    KIND_BEGIN, KIND_KW_END, KIND_IF, KIND_THEN, KIND_WHILE, KIND_DO,
    KIND_RETURN, KIND_FUNCTION, KIND_VAR, KIND_CONST, KIND_ODD, KIND_WRITE,
    KIND_WRITELN, KIND_CLASS, KIND_CLASS, KIND_ENDTYPE, KIND_OBJECT
  };

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] name_buf;
    logic [7:0]  name_cnt;
    logic [31:0] num_acc;
  } scan_state_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] number_value;
    logic [63:0] name_text;
    logic [7:0]  name_length;
    logic        last;
  } token_t;

  function automatic token_t make_token(input logic [5:0] kind,
                                        input logic [31:0] num,
                                        input logic [63:0] text,
                                        input logic [7:0] len);
    token_t t;
    t.kind         = kind;
    t.number_value = num;
    t.name_text    = text;
    t.name_length  = len;
    t.last         = 1'b0;
    return t;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           c == CH_UNDER || c == CH_TILDE;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Single-byte symbol kinds; anything unlisted is other
  function automatic logic [5:0] symbol_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_TIMES;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_EQUAL:  k = KIND_EQL;
      CH_COMMA:  k = KIND_COMMA;
      CH_PERIOD: k = KIND_PERIOD;
      CH_SEMI:   k = KIND_SEMI;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_CARET:  k = KIND_CARET;
      CH_AMP:    k = KIND_AMP;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

  // Compare a finished name against all keywords in parallel
  function automatic token_t name_token(input logic [63:0] text,
                                        input logic [7:0] len);
    token_t t;
    logic   hit;
    t   = make_token(KIND_NAME, 32'd0, text, len);
    hit = 1'b0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (!hit && len == KW_LEN[i] && text == KW_TEXT[i]) begin
        hit = 1'b1;
        t   = make_token(KW_KIND[i], 32'd0, 64'd0, 8'd0);
      end
    end
    return t;
  endfunction

endpackage

>>> hw/rtl/pl0ts_chan_if.sv
`timescale 1ns / 1ps
// Source byte channel
interface pl0ts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// Token channel
interface pl0ts_tok_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [31:0] number_value;
  logic [63:0] name_text;
  logic [7:0]  name_length;
  logic        last;

  modport source (output valid, output kind, output number_value, output name_text,
                  output name_length, output last, input ready);
  modport sink   (input valid, input kind, input number_value, input name_text,
                  input name_length, input last, output ready);
endinterface

>>> hw/rtl/pl0_token_scanner_core.sv
`timescale 1ns / 1ps
// PL/0-style token scanner core.
//
// in_byte: one source byte per word (ch); byte 0 ends the text, flushes any
//   pending token and yields an end token, then the scanner starts afresh.
// out_tok: one token per word: kind, number_value, name_text, name_length,
//   and last, which marks the final token caused by an input byte.
// Both channels use valid/ready; a word moves when both are high.
//
// A byte is registered in the input register, scanned from there once the
// output queue has room for its tokens, and its tokens are registered in the
// queue, whose head is shown on out_tok.
// Throughput: one byte per cycle while out_tok is ready and each byte yields
// at most one token. A byte that yields two tokens is scanned only into an
// empty output queue and fills it, so it waits while a token from the byte
// before it is still queued; the output queue holds two entries.
// Reset (synchronous, active low) empties the input register and the queue
// and returns the scanner to idle with cleared buffers.
// When out_tok stalls, the queue fills and in_byte.ready drops; nothing is
// lost and the byte waiting in the input register holds until it can scan.
module pl0_token_scanner_core (
  input  logic                 clk,
  input  logic                 rst_n,
  pl0ts_byte_if.sink           in_byte,
  pl0ts_tok_if.source          out_tok
);

  `include "pl0_token_scanner_core_macros.svh"

  // Input register
  logic                   in_valid_r;
  logic [7:0]             in_ch_r;

  // Scanner state
  pl0ts_pkg::scan_state_t st_r;
  pl0ts_pkg::scan_state_t st_nxt;

  // Step results
  pl0ts_pkg::token_t      tok0;
  pl0ts_pkg::token_t      tok1;
  logic [1:0]             n_tok;

  // Output queue: q0_r is the head shown on out_tok
  pl0ts_pkg::token_t      q0_r;
  pl0ts_pkg::token_t      q1_r;
  logic [1:0]             qn_r;
  pl0ts_pkg::token_t      q0_nxt;
  pl0ts_pkg::token_t      q1_nxt;
  logic [1:0]             qn_nxt;
  logic [1:0]             qn_left;

  logic                   consume;
  logic                   pop;
  logic                   take;

  pl0ts_step u_step (
    .st     (st_r),
    .ch     (in_ch_r),
    .st_nxt (st_nxt),
    .tok0   (tok0),
    .tok1   (tok1),
    .n_tok  (n_tok)
  );

  // Scan the held byte only when the queue has room for all its tokens;
  // the room check uses registered counts so ready never waits on out_tok.
  assign consume = in_valid_r &&
                   (n_tok == 2'd0 || qn_r == 2'd0 || (n_tok == 2'd1 && qn_r == 2'd1));
  assign in_byte.ready = !in_valid_r || consume;
  assign take    = in_byte.valid && in_byte.ready;
  assign pop     = (qn_r != 2'd0) && out_tok.ready;

  // Capture a new byte; drop the held one once scanned
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (take) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_ch_r <= in_byte.ch;
    end
  end

  // Advance scanner state on every scanned byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: pl0ts_pkg::MODE_IDLE, name_buf: 64'd0, name_cnt: 8'd0,
                num_acc: 32'd0};
    end else if (consume) begin
      st_r <= st_nxt;
    end
  end

  // Queue update: shift out the head on pop, then append new tokens
  always_comb begin
    qn_left = qn_r - {1'b0, pop};
    q0_nxt  = pop ? q1_r : q0_r;
    q1_nxt  = q1_r;
    qn_nxt  = qn_left;
    if (consume && n_tok != 2'd0) begin
      if (qn_left == 2'd0) begin
        q0_nxt = tok0;
        if (n_tok == 2'd2) begin
          q1_nxt = tok1;
        end
      end else begin
        q1_nxt = tok0;
      end
      qn_nxt = qn_left + n_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qn_r <= 2'd0;
    end else begin
      qn_r <= qn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_tok.valid        = (qn_r != 2'd0);
  assign out_tok.kind         = q0_r.kind;
  assign out_tok.number_value = q0_r.number_value;
  assign out_tok.name_text    = q0_r.name_text;
  assign out_tok.name_length  = q0_r.name_length;
  assign out_tok.last         = q0_r.last;

  `PL0TS_ASSERT_NOW(a_pair_needs_empty_queue, consume && n_tok == 2'd2, qn_r == 2'd0,
    "two-token byte scanned while queue not empty")
  `PL0TS_ASSERT_NOW(a_full_queue_no_push, consume && qn_r == 2'd2, n_tok == 2'd0,
    "token pushed into full queue")
  `PL0TS_ASSERT_NOW(a_pair_last_order, consume && n_tok == 2'd2, !tok0.last && tok1.last,
    "last flag misplaced on token pair")
  `PL0TS_ASSERT_NEXT(a_drain_count, pop && qn_r == 2'd2 && !consume, qn_r == 2'd1,
    "queue count wrong after pop from full queue")

endmodule

>>> hw/rtl/pl0ts_step.sv
`timescale 1ns / 1ps
// One scanner step: current state plus one byte gives the next state and
// up to two tokens, first in tok0.
module pl0ts_step (
  input  pl0ts_pkg::scan_state_t st,
  input  logic [7:0]             ch,
  output pl0ts_pkg::scan_state_t st_nxt,
  output pl0ts_pkg::token_t      tok0,
  output pl0ts_pkg::token_t      tok1,
  output logic [1:0]             n_tok
);

  logic                  word_ch;
  logic                  pend_v;
  pl0ts_pkg::token_t     pend_tok;
  logic                  take_fresh;
  logic [2:0]            f_mode;
  logic                  f_emit;
  logic [5:0]            f_kind;
  pl0ts_pkg::token_t     f_tok;
  logic [31:0]           acc_x10;

  assign word_ch = pl0ts_pkg::is_letter(ch) || pl0ts_pkg::is_digit(ch);
  assign acc_x10 = {st.num_acc[28:0], 3'b000} + {st.num_acc[30:0], 1'b0};

  // Decode a byte seen with no token pending
  always_comb begin
    f_mode = pl0ts_pkg::MODE_IDLE;
    f_emit = 1'b0;
    f_kind = pl0ts_pkg::KIND_OTHER;
    if (ch == pl0ts_pkg::CH_NUL) begin
      f_emit = 1'b1;
      f_kind = pl0ts_pkg::KIND_END;
    end else if (ch == pl0ts_pkg::CH_SPACE || ch == pl0ts_pkg::CH_TAB ||
                 ch == pl0ts_pkg::CH_LF || ch == pl0ts_pkg::CH_CR) begin
      f_mode = pl0ts_pkg::MODE_IDLE;
    end else if (ch == pl0ts_pkg::CH_HASH) begin
      f_mode = pl0ts_pkg::MODE_COMMENT;
    end else if (pl0ts_pkg::is_letter(ch)) begin
      f_mode = pl0ts_pkg::MODE_NAME;
    end else if (pl0ts_pkg::is_digit(ch)) begin
      f_mode = pl0ts_pkg::MODE_NUMBER;
    end else if (ch == pl0ts_pkg::CH_COLON) begin
      f_mode = pl0ts_pkg::MODE_COLON;
    end else if (ch == pl0ts_pkg::CH_LESS) begin
      f_mode = pl0ts_pkg::MODE_LESS;
    end else if (ch == pl0ts_pkg::CH_GREATR) begin
      f_mode = pl0ts_pkg::MODE_GREATER;
    end else begin
      f_emit = 1'b1;
      f_kind = pl0ts_pkg::symbol_kind(ch);
    end
  end

  assign f_tok = pl0ts_pkg::make_token(f_kind, 32'd0, 64'd0, 8'd0);

  always_comb begin
    st_nxt     = st;
    pend_v     = 1'b0;
    pend_tok   = pl0ts_pkg::make_token(pl0ts_pkg::KIND_END, 32'd0, 64'd0, 8'd0);
    take_fresh = 1'b0;
    unique case (st.mode)
      pl0ts_pkg::MODE_COMMENT: begin
        if (ch == pl0ts_pkg::CH_HASH) begin
          st_nxt.mode = pl0ts_pkg::MODE_IDLE;
        end else if (ch == pl0ts_pkg::CH_NUL) begin
          st_nxt.mode = pl0ts_pkg::MODE_IDLE;
          pend_v      = 1'b1;
        end
      end
      pl0ts_pkg::MODE_NAME: begin
        if (word_ch) begin
          for (int i = 0; i < pl0ts_pkg::NAME_CHARS; i++) begin
            if (st.name_cnt == 8'(i)) begin
              st_nxt.name_buf[8*i +: 8] = st.name_buf[8*i +: 8] | ch;
            end
          end
          if (st.name_cnt != 8'hFF) begin
            st_nxt.name_cnt = st.name_cnt + 8'd1;
          end
        end else begin
          pend_v     = 1'b1;
          pend_tok   = pl0ts_pkg::name_token(st.name_buf, st.name_cnt);
          take_fresh = 1'b1;
        end
      end
      pl0ts_pkg::MODE_NUMBER: begin
        if (pl0ts_pkg::is_digit(ch)) begin
          st_nxt.num_acc = acc_x10 + {28'd0, ch[3:0]};
        end else begin
          pend_v     = 1'b1;
          pend_tok   = pl0ts_pkg::make_token(pl0ts_pkg::KIND_NUMBER, st.num_acc,
                                             64'd0, 8'd0);
          take_fresh = 1'b1;
        end
      end
      pl0ts_pkg::MODE_COLON: begin
        pend_v = 1'b1;
        if (ch == pl0ts_pkg::CH_EQUAL) begin
          st_nxt.mode = pl0ts_pkg::MODE_IDLE;
          pend_tok    = pl0ts_pkg::make_token(pl0ts_pkg::KIND_ASSIGN, 32'd0, 64'd0, 8'd0);
        end else begin
          pend_tok   = pl0ts_pkg::make_token(pl0ts_pkg::KIND_COLON, 32'd0, 64'd0, 8'd0);
          take_fresh = 1'b1;
        end
      end
      pl0ts_pkg::MODE_LESS: begin
        pend_v = 1'b1;
        if (ch == pl0ts_pkg::CH_EQUAL) begin
          st_nxt.mode = pl0ts_pkg::MODE_IDLE;
          pend_tok    = pl0ts_pkg::make_token(pl0ts_pkg::KIND_LSSEQ, 32'd0, 64'd0, 8'd0);
        end else if (ch == pl0ts_pkg::CH_GREATR) begin
          st_nxt.mode = pl0ts_pkg::MODE_IDLE;
          pend_tok    = pl0ts_pkg::make_token(pl0ts_pkg::KIND_NOTEQ, 32'd0, 64'd0, 8'd0);
        end else begin
          pend_tok   = pl0ts_pkg::make_token(pl0ts_pkg::KIND_LSS, 32'd0, 64'd0, 8'd0);
          take_fresh = 1'b1;
        end
      end
      pl0ts_pkg::MODE_GREATER: begin
        pend_v = 1'b1;
        if (ch == pl0ts_pkg::CH_EQUAL) begin
          st_nxt.mode = pl0ts_pkg::MODE_IDLE;
          pend_tok    = pl0ts_pkg::make_token(pl0ts_pkg::KIND_GTREQ, 32'd0, 64'd0, 8'd0);
        end else begin
          pend_tok   = pl0ts_pkg::make_token(pl0ts_pkg::KIND_GTR, 32'd0, 64'd0, 8'd0);
          take_fresh = 1'b1;
        end
      end
      default: begin
        take_fresh = 1'b1;
      end
    endcase

    // Start the next token; buffers only matter in the mode that set them
    if (take_fresh) begin
      st_nxt.mode     = f_mode;
      st_nxt.name_buf = {56'd0, ch};
      st_nxt.name_cnt = 8'd1;
      st_nxt.num_acc  = {28'd0, ch[3:0]};
    end
  end

  // Order the tokens and mark the final one
  always_comb begin
    tok0  = pend_tok;
    tok1  = f_tok;
    n_tok = 2'd0;
    if (pend_v) begin
      if (take_fresh && f_emit) begin
        n_tok     = 2'd2;
        tok1.last = 1'b1;
      end else begin
        n_tok     = 2'd1;
        tok0.last = 1'b1;
      end
    end else if (take_fresh && f_emit) begin
      n_tok     = 2'd1;
      tok0      = f_tok;
      tok0.last = 1'b1;
    end
  end

endmodule
